>>> src/thq_pkg.sv
package thq_pkg;

   // field widths fixed by the command format
   localparam int KEY_W = 64;
   localparam int ID_W  = 16;
   localparam int OCC_W = 7;

   // default number of heap slots
   localparam int HEAP_DEPTH_DEFAULT = 64;

   // command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_PEEK   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // one heap slot
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
   } entry_type;

   // port enables of the heap memory
   typedef struct packed {
      logic wr_en;
      logic rd_a_en;
      logic rd_b_en;
   } ram_ctl_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_UP_CMP,
      S_RM_LOAD,
      S_PEEK,
      S_DN,
      S_DN_LEFT,
      S_DN_RIGHT
   } state_type;

endpackage

>>> src/timer_min_heap_queue.sv
// Binary min-heap of timer entries (64-bit deadline key, 16-bit id) held in a
// two-read, one-write memory. A command word is taken when start is high and
// busy is low; busy then stays high until the command is done, unless it
// finishes at once. Exactly one result word per command appears on the rsp_
// ports with rsp_strobe high for a single cycle: the first cycle in which busy
// is low again (or the cycle after acceptance for commands that finish at
// once); the receiver cannot stall, so it must capture the word in that cycle.
// Timing is set by the sift sequencer, which shares a single 64-bit key
// comparator. Insert climbs level by level until the entry reaches the root
// or stops below a parent that is not greater. Remove takes the root, moves
// the last entry to the root and descends, unless that was the only entry.
// Peek reads the root, and full/empty/unused-code commands finish at once.
// The next command may be issued in the cycle the result strobe is shown.
module timer_min_heap_queue #(
   parameter int HEAP_DEPTH = thq_pkg::HEAP_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [thq_pkg::KEY_W-1:0]  req_deadline_key,
   input  logic [thq_pkg::ID_W-1:0]   req_entry_id,
   output logic                       rsp_strobe,
   output logic [thq_pkg::ID_W-1:0]   rsp_result_id,
   output logic [1:0]                 rsp_status,
   output logic [thq_pkg::OCC_W-1:0]  rsp_occupancy
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int XW = AW + 2;

   thq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   thq_pkg::entry_type  moving_ff, moving_in;
   thq_pkg::entry_type  best_ff, best_in;
   logic                best_child_ff, best_child_in;
   logic [thq_pkg::ID_W-1:0] rid_ff, rid_in;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [thq_pkg::ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [thq_pkg::OCC_W-1:0] rsp_occ_ff, rsp_occ_in;

   thq_pkg::ram_ctl_type ram_ctl;
   logic [AW-1:0]        wr_addr, rd_a_addr, rd_b_addr;
   thq_pkg::entry_type   wr_data, rd_a_data, rd_b_data;

   // shared key comparator
   logic [thq_pkg::KEY_W-1:0] cmp_a, cmp_b;
   logic                      cmp_lt;

   // tree index arithmetic
   logic [AW-1:0] parent_idx;
   logic [XW-1:0] left_idx, right_idx, count_x;
   logic          left_ok, right_ok;

   thq_heap_ram #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .AW         (AW)
   ) u_ram (
      .clock     (clock),
      .ctl       (ram_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign parent_idx = AW'((pos_ff - AW'(1)) >> 1);
   assign left_idx   = XW'({pos_ff, 1'b1});
   assign right_idx  = XW'({pos_ff, 1'b0}) + XW'(2);
   assign count_x    = XW'(count_ff);
   assign left_ok    = left_idx < count_x;
   assign right_ok   = right_idx < count_x;
   assign cmp_lt     = cmp_a < cmp_b;

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= thq_pkg::S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pos_ff        <= pos_in;
      moving_ff     <= moving_in;
      best_ff       <= best_in;
      best_child_ff <= best_child_in;
      rid_ff        <= rid_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // sift sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      moving_in     = moving_ff;
      best_in       = best_ff;
      best_child_in = best_child_ff;
      rid_in        = rid_ff;
      rsp_strobe_in = 1'b0;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      ram_ctl       = '0;
      wr_addr       = pos_ff;
      wr_data       = moving_ff;
      rd_a_addr     = '0;
      rd_b_addr     = '0;
      cmp_a         = moving_ff.key;
      cmp_b         = rd_a_data.key;

      case (state_ff)
         thq_pkg::S_IDLE: begin
            if (start) begin
               rsp_id_in     = '0;
               rsp_status_in = thq_pkg::ST_OK;
               rsp_occ_in    = thq_pkg::OCC_W'(count_ff);
               case (req_command)
                  thq_pkg::CMD_INSERT: begin
                     if (count_ff == CW'(HEAP_DEPTH)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = thq_pkg::ST_FULL;
                     end else begin
                        pos_in        = AW'(count_ff);
                        count_in      = count_ff + CW'(1);
                        moving_in.key = req_deadline_key;
                        moving_in.id  = req_entry_id;
                        state_in      = thq_pkg::S_UP;
                     end
                  end
                  thq_pkg::CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = thq_pkg::ST_EMPTY;
                     end else begin
                        ram_ctl.rd_a_en = 1'b1;
                        ram_ctl.rd_b_en = 1'b1;
                        rd_b_addr       = AW'(count_ff - CW'(1));
                        count_in        = count_ff - CW'(1);
                        state_in        = thq_pkg::S_RM_LOAD;
                     end
                  end
                  thq_pkg::CMD_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = thq_pkg::ST_EMPTY;
                     end else begin
                        ram_ctl.rd_a_en = 1'b1;
                        state_in        = thq_pkg::S_PEEK;
                     end
                  end
                  default: begin
                     // unused code: no change, plain ok
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         // climb: fetch parent, or settle at the root
         thq_pkg::S_UP: begin
            if (pos_ff == '0) begin
               ram_ctl.wr_en = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_occ_in    = thq_pkg::OCC_W'(count_ff);
               state_in      = thq_pkg::S_IDLE;
            end else begin
               ram_ctl.rd_a_en = 1'b1;
               rd_a_addr       = parent_idx;
               state_in        = thq_pkg::S_UP_CMP;
            end
         end

         // parent moves down only when its key is strictly greater
         thq_pkg::S_UP_CMP: begin
            cmp_a         = moving_ff.key;
            cmp_b         = rd_a_data.key;
            ram_ctl.wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd_a_data;
               pos_in   = parent_idx;
               state_in = thq_pkg::S_UP;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_occ_in    = thq_pkg::OCC_W'(count_ff);
               state_in      = thq_pkg::S_IDLE;
            end
         end

         // root id out, last entry becomes the moving entry
         thq_pkg::S_RM_LOAD: begin
            rid_in    = rd_a_data.id;
            moving_in = rd_b_data;
            pos_in    = '0;
            if (count_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_id_in     = rd_a_data.id;
               rsp_occ_in    = thq_pkg::OCC_W'(count_ff);
               state_in      = thq_pkg::S_IDLE;
            end else begin
               state_in = thq_pkg::S_DN;
            end
         end

         thq_pkg::S_PEEK: begin
            rsp_strobe_in = 1'b1;
            rsp_id_in     = rd_a_data.id;
            rsp_occ_in    = thq_pkg::OCC_W'(count_ff);
            state_in      = thq_pkg::S_IDLE;
         end

         // descend: fetch both children, or settle at a leaf
         thq_pkg::S_DN: begin
            if (!left_ok) begin
               ram_ctl.wr_en = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_id_in     = rid_ff;
               rsp_occ_in    = thq_pkg::OCC_W'(count_ff);
               state_in      = thq_pkg::S_IDLE;
            end else begin
               ram_ctl.rd_a_en = 1'b1;
               ram_ctl.rd_b_en = 1'b1;
               rd_a_addr       = AW'(left_idx);
               rd_b_addr       = AW'(right_idx);
               state_in        = thq_pkg::S_DN_LEFT;
            end
         end

         // left child against the moving entry
         thq_pkg::S_DN_LEFT: begin
            cmp_a = rd_a_data.key;
            cmp_b = moving_ff.key;
            if (cmp_lt) begin
               best_in       = rd_a_data;
               best_child_in = 1'b1;
            end else begin
               best_in       = moving_ff;
               best_child_in = 1'b0;
            end
            state_in = thq_pkg::S_DN_RIGHT;
         end

         // right child against the best so far, then move or settle
         thq_pkg::S_DN_RIGHT: begin
            cmp_a         = rd_b_data.key;
            cmp_b         = best_ff.key;
            ram_ctl.wr_en = 1'b1;
            if (right_ok && cmp_lt) begin
               wr_data  = rd_b_data;
               pos_in   = AW'(right_idx);
               state_in = thq_pkg::S_DN;
            end else if (best_child_ff) begin
               wr_data  = best_ff;
               pos_in   = AW'(left_idx);
               state_in = thq_pkg::S_DN;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_id_in     = rid_ff;
               rsp_occ_in    = thq_pkg::OCC_W'(count_ff);
               state_in      = thq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = thq_pkg::S_IDLE;
         end
      endcase
   end

   assign busy          = state_ff != thq_pkg::S_IDLE;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // entry count never passes the heap size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HEAP_DEPTH))
      else $error("entry count above heap size");

   // an accepted command either starts work or answers at once
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted command left no trace");

   // full status only with a full heap
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == thq_pkg::ST_FULL) |-> count_ff == CW'(HEAP_DEPTH))
      else $error("full status with room left");

   // empty status only with an empty heap
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == thq_pkg::ST_EMPTY) |-> count_ff == '0)
      else $error("empty status with entries held");

   // no result while a command is still in work
   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> !rsp_strobe)
      else $error("result strobe during sift");

endmodule

>>> src/thq_heap_ram.sv
module thq_heap_ram #(
   parameter int HEAP_DEPTH = thq_pkg::HEAP_DEPTH_DEFAULT,
   parameter int AW         = $clog2(HEAP_DEPTH)
) (
   input  logic                clock,
   input  thq_pkg::ram_ctl_type ctl,
   input  logic [AW-1:0]       wr_addr,
   input  thq_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_a_addr,
   input  logic [AW-1:0]       rd_b_addr,
   output thq_pkg::entry_type  rd_a_data,
   output thq_pkg::entry_type  rd_b_data
);

   thq_pkg::entry_type mem [HEAP_DEPTH];
   thq_pkg::entry_type rd_a_data_ff;
   thq_pkg::entry_type rd_b_data_ff;

   // one write port, two registered read ports; read data holds when not enabled
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_a_en) begin
         rd_a_data_ff <= mem[rd_a_addr];
      end
      if (ctl.rd_b_en) begin
         rd_b_data_ff <= mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH = thq_pkg::HEAP_DEPTH_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 900;
   localparam int MAX_SHOWN = 10;

   // one result word as the heap should report it
   typedef struct {
      logic [thq_pkg::ID_W-1:0]  result_id;
      logic [1:0]                status;
      logic [thq_pkg::OCC_W-1:0] occupancy;
   } answer_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_command;
   logic [thq_pkg::KEY_W-1:0] req_deadline_key;
   logic [thq_pkg::ID_W-1:0]  req_entry_id;
   logic                      rsp_strobe;
   logic [thq_pkg::ID_W-1:0]  rsp_result_id;
   logic [1:0]                rsp_status;
   logic [thq_pkg::OCC_W-1:0] rsp_occupancy;

   // shadow copy of the heap
   logic [thq_pkg::KEY_W-1:0] heap_keys [DEPTH];
   logic [thq_pkg::ID_W-1:0]  heap_ids [DEPTH];
   int                        heap_count;

   answer_type        answer_q [$];
   int                mismatches;
   int                items_sent;
   bit                no_idle;

   timer_min_heap_queue #(
      .HEAP_DEPTH(DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_deadline_key (req_deadline_key),
      .req_entry_id     (req_entry_id),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_id    (rsp_result_id),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // heap slot swap
   function automatic void swap_slots(int a, int b);
      logic [thq_pkg::KEY_W-1:0] k;
      logic [thq_pkg::ID_W-1:0]  v;
      k = heap_keys[a];
      v = heap_ids[a];
      heap_keys[a] = heap_keys[b];
      heap_ids[a]  = heap_ids[b];
      heap_keys[b] = k;
      heap_ids[b]  = v;
   endfunction

   // apply one command to the shadow heap, return the word it yields
   function automatic answer_type shadow_heap_apply(logic [1:0] cmd,
                                                    logic [thq_pkg::KEY_W-1:0] key,
                                                    logic [thq_pkg::ID_W-1:0] id);
      answer_type ans;
      int      pos;
      int      parent;
      int      best;
      int      lc;
      int      rc;
      ans.result_id = '0;
      ans.status    = thq_pkg::ST_OK;
      case (cmd)
         thq_pkg::CMD_INSERT: begin
            if (heap_count >= DEPTH) begin
               ans.status = thq_pkg::ST_FULL;
            end else begin
               heap_keys[heap_count] = key;
               heap_ids[heap_count]  = id;
               heap_count++;
               // climb while the parent is strictly greater
               pos = heap_count - 1;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (heap_keys[parent] <= heap_keys[pos]) break;
                  swap_slots(parent, pos);
                  pos = parent;
               end
            end
         end
         thq_pkg::CMD_REMOVE: begin
            if (heap_count == 0) begin
               ans.status = thq_pkg::ST_EMPTY;
            end else begin
               ans.result_id = heap_ids[0];
               heap_count--;
               heap_keys[0] = heap_keys[heap_count];
               heap_ids[0]  = heap_ids[heap_count];
               // descend; left child wins a tie, move only if strictly smaller
               pos = 0;
               forever begin
                  best = pos;
                  lc = 2 * pos + 1;
                  rc = 2 * pos + 2;
                  if (lc < heap_count && heap_keys[lc] < heap_keys[best]) best = lc;
                  if (rc < heap_count && heap_keys[rc] < heap_keys[best]) best = rc;
                  if (best == pos) break;
                  swap_slots(pos, best);
                  pos = best;
               end
            end
         end
         thq_pkg::CMD_PEEK: begin
            if (heap_count == 0) ans.status = thq_pkg::ST_EMPTY;
            else ans.result_id = heap_ids[0];
         end
         default: begin
            // unused code: no change
         end
      endcase
      ans.occupancy = heap_count[thq_pkg::OCC_W-1:0];
      return ans;
   endfunction

   // drive one command word and wait for it to be taken
   task automatic send_word(input logic [1:0] cmd, input logic [thq_pkg::KEY_W-1:0] key,
                            input logic [thq_pkg::ID_W-1:0] id);
      @(negedge clock);
      start            = 1'b1;
      req_command      = cmd;
      req_deadline_key = key;
      req_entry_id     = id;
      do @(posedge clock); while (busy);
      answer_q.push_back(shadow_heap_apply(cmd, key, id));
      items_sent++;
   endtask

   // idle the request side by holding start low
   task automatic pause(input int n);
      repeat (n) @(negedge clock) start = 1'b0;
   endtask

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // keys: full range, a small tie-prone pool, and the extremes
   function automatic logic [thq_pkg::KEY_W-1:0] rand_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return {$urandom, $urandom};
      if (r < 80) return thq_pkg::KEY_W'($urandom_range(0, 7));
      if (r < 90) return r[0] ? '1 : '0;
      return {32'hFFFF_FFFF, 29'h0, 3'($urandom_range(0, 7))};
   endfunction

   task automatic send_gap(input logic [1:0] cmd, input logic [thq_pkg::KEY_W-1:0] key,
                           input logic [thq_pkg::ID_W-1:0] id);
      send_word(cmd, key, id);
      pause(gap_len());
   endtask

   // record a failure, show only the first few
   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("%0t: %s", $realtime, msg);
   endtask

   // result checker
   always @(posedge clock) begin : check_blk
      answer_type exp_a;
      if (!reset && rsp_strobe) begin
         if (answer_q.size() == 0) begin
            note_mismatch($sformatf("unexpected word id=%h st=%0d occ=%0d",
                                    rsp_result_id, rsp_status, rsp_occupancy));
         end else begin
            exp_a = answer_q.pop_front();
            if (rsp_result_id !== exp_a.result_id || rsp_status !== exp_a.status ||
                rsp_occupancy !== exp_a.occupancy)
               note_mismatch($sformatf("exp id=%h st=%0d occ=%0d got id=%h st=%0d occ=%0d",
                                       exp_a.result_id, exp_a.status, exp_a.occupancy,
                                       rsp_result_id, rsp_status, rsp_occupancy));
         end
      end
   end

   // extremes, every command, empty and unused cases, ties
   task automatic test_directed();
      send_gap(thq_pkg::CMD_REMOVE, '0, '0);
      send_gap(thq_pkg::CMD_PEEK, '1, '1);
      send_gap(CMD_UNUSED, '1, '1);
      send_gap(thq_pkg::CMD_INSERT, '1, 16'hFFFF);
      send_gap(thq_pkg::CMD_PEEK, '0, '0);
      send_gap(thq_pkg::CMD_INSERT, '0, 16'h0000);
      send_gap(thq_pkg::CMD_PEEK, '0, '0);
      send_gap(thq_pkg::CMD_INSERT, '0, 16'h1234);
      send_gap(thq_pkg::CMD_INSERT, '1, 16'h0001);
      send_gap(thq_pkg::CMD_INSERT, 64'd5, 16'hAAAA);
      send_gap(thq_pkg::CMD_INSERT, 64'd5, 16'h5555);
      send_gap(CMD_UNUSED, {$urandom, $urandom}, 16'($urandom));
      send_gap(thq_pkg::CMD_PEEK, '0, '0);
      repeat (6) send_gap(thq_pkg::CMD_REMOVE, '1, '1);
      send_gap(thq_pkg::CMD_REMOVE, '0, '0);
      send_gap(thq_pkg::CMD_PEEK, '0, '0);
   endtask

   // fill to capacity, overflow, drain to empty
   task automatic test_fill_drain();
      no_idle = 1'b0;
      while (heap_count < DEPTH) send_gap(thq_pkg::CMD_INSERT, rand_key(), 16'($urandom));
      send_gap(thq_pkg::CMD_INSERT, rand_key(), 16'($urandom));
      send_gap(thq_pkg::CMD_INSERT, '0, 16'($urandom));
      send_gap(thq_pkg::CMD_PEEK, rand_key(), 16'($urandom));
      no_idle = 1'b1;
      while (heap_count > 32) send_gap(thq_pkg::CMD_REMOVE, rand_key(), 16'($urandom));
      no_idle = 1'b0;
      while (heap_count > 0) send_gap(thq_pkg::CMD_REMOVE, rand_key(), 16'($urandom));
      send_gap(thq_pkg::CMD_REMOVE, rand_key(), 16'($urandom));
   endtask

   // random mix in segments that push occupancy up, hold it, or pull it down
   task automatic test_random_mix();
      int target;
      int seg_len;
      int ins_pct;
      int r;
      logic [1:0] cmd;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         seg_len = $urandom_range(30, 70);
         case ($urandom_range(0, 2))
            0:       ins_pct = 85;
            1:       ins_pct = 50;
            default: ins_pct = 15;
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         repeat (seg_len) begin
            r = $urandom_range(0, 99);
            if (r < 3)                            cmd = CMD_UNUSED;
            else if (r < 13)                      cmd = thq_pkg::CMD_PEEK;
            else if (r < 13 + ins_pct * 87 / 100) cmd = thq_pkg::CMD_INSERT;
            else                                  cmd = thq_pkg::CMD_REMOVE;
            send_gap(cmd, rand_key(), 16'($urandom));
         end
      end
      no_idle = 1'b0;
   endtask

   // main sequence
   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_command      = thq_pkg::CMD_INSERT;
      req_deadline_key = '0;
      req_entry_id     = '0;
      heap_count       = 0;
      mismatches       = 0;
      items_sent       = 0;
      no_idle          = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      test_directed();
      test_fill_drain();
      test_random_mix();

      @(negedge clock) start = 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      if (answer_q.size() != 0) $display("%0d words never arrived", answer_q.size());
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
src/thq_pkg.sv
src/thq_heap_ram.sv
src/timer_min_heap_queue.sv
verif/tb.sv
